// File: hw/rtl/stimulation_pulse_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Stimulation pulse sequencer assertion macros
// Shorthand for clocked assertions on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STIMULATION_PULSE_SEQUENCER_DEFINES_SVH
`define STIMULATION_PULSE_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/spsq_pkg.sv
// ----------------------------------------------------------------------------
// Stimulation pulse sequencer package
// Shared constants, register codes, config and result structs, helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package spsq_pkg;

  // Timing constants
  localparam int unsigned TICKS_PER_MS         = 1000;
  localparam int unsigned DISCHARGE_WAIT_TICKS = 4000;
  localparam int unsigned DISCHARGE_TOGGLES    = 100;
  localparam int unsigned TOGGLE_PERIOD_TICKS  = 2;

  localparam int TPM_W     = $clog2(TICKS_PER_MS + 1);
  localparam int MS_W      = 16;
  localparam int MS_PROD_W = MS_W + TPM_W;
  // Longest phase: 65535 ms worth of ticks.
  localparam int TIMER_W   = $clog2(longint'(65535) * longint'(TICKS_PER_MS) + 1);
  localparam int TOG_W     = 7;

  // Field widths
  localparam int DUTY_W   = 16;
  localparam int LEVEL_W  = 7;
  localparam int SLOT_W   = 16;
  localparam int LIM_W    = 15;
  localparam int SCALED_W = 22;

  // Duty scaling: level * (full_scale * 42 / 100) / 100
  localparam int unsigned DUTY_LIMIT_PCT = 42;
  localparam int unsigned PCT_SCALE      = 100;
  // Exact x/100 for x < 2^22 by multiply and shift.
  localparam int          DIV_SHIFT = 29;
  localparam int          DIV_MUL_W = 23;
  localparam longint unsigned DIV_MUL =
    ((longint'(1) << DIV_SHIFT) + longint'(PCT_SCALE) - 1) / longint'(PCT_SCALE);
  localparam int          DIV_PROD_W = SCALED_W + DIV_MUL_W;

  // Input/output pipeline
  localparam int PIPE_DEPTH  = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SENSE_LEVEL     = 3'd0,
    REG_DUTY_FULL_SCALE = 3'd1,
    REG_TRIGGER_WIDTH   = 3'd2,
    REG_SLOT_GAP        = 3'd3,
    REG_SLOTS_PER_SENSE = 3'd4,
    REG_SENSE_GAP       = 3'd5,
    REG_OUTPUT_MODE     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_ALT = 2'd0,
    MODE_POS = 2'd1,
    MODE_NEG = 2'd2,
    MODE_DC  = 2'd3
  } out_mode_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DWAIT = 3'd1,
    PH_DTOG  = 3'd2,
    PH_TRIG  = 3'd3,
    PH_SGAP  = 3'd4,
    PH_CGAP  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] sense_level;
    logic [15:0]        trigger_width;
    out_mode_e          output_mode;
    logic [SLOT_W-1:0]  slots;
    logic [TIMER_W-1:0] slot_gap_ticks;
    logic [TIMER_W-1:0] sense_gap_ticks;
    logic [DUTY_W-1:0]  duty;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] boost_duty;
    logic              net_p;
    logic              net_n;
    logic [SLOT_W-1:0] slot_index;
    logic              cycle_end;
  } result_t;

  // ms to ticks, a zero gap still lasts one tick
  function automatic logic [TIMER_W-1:0] ms_ticks(logic [MS_W-1:0] ms);
    logic [MS_PROD_W-1:0] p;
    p = MS_PROD_W'(ms) * MS_PROD_W'(TICKS_PER_MS);
    if (p == '0) begin
      p = MS_PROD_W'(1);
    end
    return p[TIMER_W-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] div100(logic [SCALED_W-1:0] x);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(x) * DIV_PROD_W'(DIV_MUL);
    return p[DIV_SHIFT +: DUTY_W];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stimulation_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// Stimulation pulse sequencer
// One-microsecond tick stream in, pulse/bridge control word out per tick.
// ----------------------------------------------------------------------------
// Each input word is one tick (run in bit 0). While run is high the block
// repeats a sense cycle of slots_per_sense pulse slots and a sense gap; each
// slot sets the boost duty, fires the bridge trigger in the selected mode and
// waits the slot gap; with sense_level 0 it first discharges (duty 0, 4 ms
// wait, joint pin toggles every 2 ticks). Run low drops back to idle.
// Throughput is one word per clock while the receiver keeps up; a word
// taken passes 5 input stages, then the result register, to the master side,
// the input delay line letting the derived duty settle. Config writes are
// always ready; the registers that derive duty and gap tick counts after a
// write are covered by the input delay line.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stimulation_pulse_sequencer_defines.svh"

module stimulation_pulse_sequencer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tick stream
  input  wire logic                               s_tvalid_i,
  output      logic                               s_tready_o,
  input  wire logic [spsq_pkg::IN_TDATA_W-1:0]    s_tdata_i,  // [0] run, [7:1] zero
  // result stream
  output      logic                               m_tvalid_o,
  input  wire logic                               m_tready_i,
  // [15:0] boost_duty, [16] net_p, [17] net_n, [33:18] slot_index,
  // [34] cycle_end, [39:35] zero
  output      logic [spsq_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  // config write channel
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [spsq_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [spsq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int LAST = spsq_pkg::PIPE_DEPTH - 1;

  spsq_pkg::cfg_t    cfg;
  spsq_pkg::result_t res;
  spsq_pkg::result_t out_q;

  logic [spsq_pkg::PIPE_DEPTH-1:0] vld_q;
  logic [spsq_pkg::PIPE_DEPTH-1:0] run_q;
  logic [spsq_pkg::PIPE_DEPTH:0]   stg_rdy;
  logic                            out_vld_q;
  logic                            out_rdy;
  logic                            core_step;

  assign cfg_ready_o = 1'b1;

  spsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Bubble-collapsing delay line: a stage takes a word when it is empty or
  // its own word moves on, so input keeps flowing into empty stages while a result waits.
  assign out_rdy = !out_vld_q || m_tready_i;

  always_comb begin
    stg_rdy[spsq_pkg::PIPE_DEPTH] = out_rdy;
    for (int k = LAST; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign s_tready_o = stg_rdy[0];
  assign core_step  = vld_q[LAST] && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        vld_q[0] <= s_tvalid_i;
      end
      for (int k = 1; k < spsq_pkg::PIPE_DEPTH; k++) begin
        if (stg_rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      run_q[0] <= s_tdata_i[0];
    end
    for (int k = 1; k < spsq_pkg::PIPE_DEPTH; k++) begin
      if (stg_rdy[k]) begin
        run_q[k] <= run_q[k-1];
      end
    end
  end

  // The sequencer state advances exactly once per word entering the
  // result register.
  spsq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (core_step),
    .run_i  (run_q[LAST]),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (core_step) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_step) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {5'b0, out_q.cycle_end, out_q.slot_index, out_q.net_n,
                       out_q.net_p, out_q.boost_duty};

  // accepted word lands in the first stage
  `SPSQ_ASSERT_NEXT(a_accept_fills, s_tvalid_i && s_tready_o, vld_q[0],
                    "accepted word lost at first stage")
  // a sequencer step always produces a visible result
  `SPSQ_ASSERT_NEXT(a_step_shows, core_step, m_tvalid_o,
                    "core stepped without a result word")
  // a waiting result is never overwritten
  `SPSQ_ASSERT_NOW(a_no_overwrite, m_tvalid_o && !m_tready_i, !core_step,
                   "result register overwritten while stalled")

endmodule

`default_nettype wire

// File: hw/rtl/spsq_cfg.sv
// ----------------------------------------------------------------------------
// Stimulation pulse sequencer configuration
// Register file plus a short pipeline that derives duty and gap tick counts.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [spsq_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [spsq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output spsq_pkg::cfg_t                        cfg_o
);

  logic [spsq_pkg::LEVEL_W-1:0] sense_level_q;
  logic [15:0]                  full_scale_q;
  logic [15:0]                  trig_width_q;
  logic [15:0]                  slot_gap_q;
  logic [15:0]                  slots_q;
  logic [15:0]                  sense_gap_q;
  spsq_pkg::out_mode_e          mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_level_q <= '0;
      full_scale_q  <= 16'd255;
      trig_width_q  <= 16'd50;
      slot_gap_q    <= 16'd3;
      slots_q       <= 16'd6;
      sense_gap_q   <= 16'd100;
      mode_q        <= spsq_pkg::MODE_ALT;
    end else if (cfg_valid_i) begin
      case (spsq_pkg::cfg_reg_e'(cfg_addr_i))
        spsq_pkg::REG_SENSE_LEVEL:     sense_level_q <= cfg_data_i[spsq_pkg::LEVEL_W-1:0];
        spsq_pkg::REG_DUTY_FULL_SCALE: full_scale_q  <= cfg_data_i;
        spsq_pkg::REG_TRIGGER_WIDTH:   trig_width_q  <= cfg_data_i;
        spsq_pkg::REG_SLOT_GAP:        slot_gap_q    <= cfg_data_i;
        spsq_pkg::REG_SLOTS_PER_SENSE: slots_q       <= cfg_data_i;
        spsq_pkg::REG_SENSE_GAP:       sense_gap_q   <= cfg_data_i;
        spsq_pkg::REG_OUTPUT_MODE:     mode_q <= spsq_pkg::out_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // After a write, duty settles through p42_q, lim_q, prod_q and duty_q.
  logic [spsq_pkg::SCALED_W-1:0] p42_q;
  logic [spsq_pkg::LIM_W-1:0]    lim_q;
  logic [spsq_pkg::SCALED_W-1:0] prod_q;
  logic [spsq_pkg::DUTY_W-1:0]   duty_q;
  logic [spsq_pkg::TIMER_W-1:0]  sgap_ticks_q;
  logic [spsq_pkg::TIMER_W-1:0]  cgap_ticks_q;
  logic [spsq_pkg::DUTY_W-1:0]   lim_full;

  assign lim_full = spsq_pkg::div100(p42_q);

  always_ff @(posedge clk_i) begin
    p42_q        <= spsq_pkg::SCALED_W'(full_scale_q) *
                    spsq_pkg::SCALED_W'(spsq_pkg::DUTY_LIMIT_PCT);
    lim_q        <= lim_full[spsq_pkg::LIM_W-1:0];
    prod_q       <= {{spsq_pkg::LIM_W{1'b0}}, sense_level_q} *
                    {{spsq_pkg::LEVEL_W{1'b0}}, lim_q};
    duty_q       <= spsq_pkg::div100(prod_q);
    sgap_ticks_q <= spsq_pkg::ms_ticks(slot_gap_q);
    cgap_ticks_q <= spsq_pkg::ms_ticks(sense_gap_q);
  end

  always_comb begin
    cfg_o.sense_level     = sense_level_q;
    cfg_o.trigger_width   = trig_width_q;
    cfg_o.output_mode     = mode_q;
    cfg_o.slots           = slots_q;
    cfg_o.slot_gap_ticks  = sgap_ticks_q;
    cfg_o.sense_gap_ticks = cgap_ticks_q;
    cfg_o.duty            = duty_q;
  end

endmodule

`default_nettype wire

// File: hw/rtl/spsq_core.sv
// ----------------------------------------------------------------------------
// Stimulation pulse sequencer core
// Phase state machine, advanced by one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        run_i,
  input  spsq_pkg::cfg_t   cfg_i,
  output spsq_pkg::result_t res_o
);

  typedef struct packed {
    spsq_pkg::phase_e                phase;
    logic [spsq_pkg::TIMER_W-1:0]    timer;
    logic [spsq_pkg::SLOT_W-1:0]     slot;
    logic                            pol;
    logic [spsq_pkg::TOG_W-1:0]      tog;
    logic                            p_lvl;
    logic                            n_lvl;
    logic [spsq_pkg::DUTY_W-1:0]     duty;
  } core_st_t;

  core_st_t st_q, st_d;

  function automatic core_st_t enter_sgap(core_st_t s, spsq_pkg::cfg_t c);
    s.phase = spsq_pkg::PH_SGAP;
    s.timer = c.slot_gap_ticks;
    return s;
  endfunction

  function automatic core_st_t enter_cgap(core_st_t s, spsq_pkg::cfg_t c);
    s.phase = spsq_pkg::PH_CGAP;
    s.timer = c.sense_gap_ticks;
    return s;
  endfunction

  function automatic core_st_t enter_trigger(core_st_t s, spsq_pkg::cfg_t c);
    core_st_t r;
    r = s;
    if (c.output_mode == spsq_pkg::MODE_ALT) begin
      r.pol = ~r.pol;
    end
    if (c.trigger_width == '0) begin
      r = enter_sgap(r, c);
    end else begin
      case (c.output_mode)
        spsq_pkg::MODE_ALT: begin
          r.p_lvl = r.pol;
          r.n_lvl = ~r.pol;
        end
        spsq_pkg::MODE_POS: begin
          r.p_lvl = 1'b1;
          r.n_lvl = 1'b0;
        end
        spsq_pkg::MODE_NEG: begin
          r.p_lvl = 1'b0;
          r.n_lvl = 1'b1;
        end
        default: r.p_lvl = 1'b1;   // DC: N pin left as is
      endcase
      r.phase = spsq_pkg::PH_TRIG;
      r.timer = spsq_pkg::TIMER_W'(c.trigger_width);
    end
    return r;
  endfunction

  function automatic core_st_t enter_slot(core_st_t s, spsq_pkg::cfg_t c);
    core_st_t r;
    r = s;
    if (c.sense_level != '0) begin
      r.duty = c.duty;
      r = enter_trigger(r, c);
    end else begin
      r.duty  = '0;
      r.phase = spsq_pkg::PH_DWAIT;
      r.timer = spsq_pkg::TIMER_W'(spsq_pkg::DISCHARGE_WAIT_TICKS);
    end
    return r;
  endfunction

  function automatic core_st_t start_cycle(core_st_t s, spsq_pkg::cfg_t c);
    core_st_t r;
    r = s;
    r.slot = '0;
    if (c.slots != '0) begin
      r = enter_slot(r, c);
    end else begin
      r = enter_cgap(r, c);
    end
    return r;
  endfunction

  function automatic core_st_t toggle_pins(core_st_t s);
    s.p_lvl = ~s.p_lvl;
    s.n_lvl = ~s.n_lvl;
    s.timer = spsq_pkg::TIMER_W'(spsq_pkg::TOGGLE_PERIOD_TICKS);
    return s;
  endfunction

  core_st_t cur, nxt;
  logic     cyc_end;

  always_comb begin
    cur     = st_q;
    cyc_end = 1'b0;
    if (!run_i) begin
      cur.phase = spsq_pkg::PH_IDLE;
      cur.timer = '0;
      cur.slot  = '0;
      nxt       = cur;
    end else begin
      if (cur.phase == spsq_pkg::PH_IDLE) begin
        cur = start_cycle(cur, cfg_i);
      end
      cyc_end = (cur.phase == spsq_pkg::PH_CGAP) &&
                (cur.timer == spsq_pkg::TIMER_W'(1));
      nxt = cur;
      if (nxt.timer != '0) begin
        nxt.timer = nxt.timer - spsq_pkg::TIMER_W'(1);
      end
      if (nxt.timer == '0) begin
        case (nxt.phase)
          spsq_pkg::PH_DWAIT: begin
            nxt.phase = spsq_pkg::PH_DTOG;
            nxt.tog   = spsq_pkg::TOG_W'(1);
            nxt       = toggle_pins(nxt);
          end
          spsq_pkg::PH_DTOG: begin
            if (nxt.tog < spsq_pkg::TOG_W'(spsq_pkg::DISCHARGE_TOGGLES)) begin
              nxt.tog = nxt.tog + spsq_pkg::TOG_W'(1);
              nxt     = toggle_pins(nxt);
            end else begin
              nxt = enter_trigger(nxt, cfg_i);
            end
          end
          spsq_pkg::PH_TRIG: begin
            nxt.p_lvl = 1'b0;
            if (cfg_i.output_mode != spsq_pkg::MODE_DC) begin
              nxt.n_lvl = 1'b0;
            end
            nxt = enter_sgap(nxt, cfg_i);
          end
          spsq_pkg::PH_SGAP: begin
            nxt.slot = nxt.slot + spsq_pkg::SLOT_W'(1);
            if (nxt.slot < cfg_i.slots) begin
              nxt = enter_slot(nxt, cfg_i);
            end else begin
              nxt = enter_cgap(nxt, cfg_i);
            end
          end
          spsq_pkg::PH_CGAP: nxt = start_cycle(nxt, cfg_i);
          default: ;
        endcase
      end
    end

    st_d = step_i ? nxt : st_q;

    res_o.boost_duty = cur.duty;
    res_o.net_p      = cur.p_lvl;
    res_o.net_n      = cur.n_lvl;
    res_o.slot_index = cur.slot;
    res_o.cycle_end  = cyc_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: spsq_pkg::PH_IDLE, default: '0};
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_stimulation_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// Stimulation pulse sequencer testbench
// Streams microsecond ticks through the sequencer under several register
// settings and checks every output word against a tick-true predictor.
// ----------------------------------------------------------------------------
// Directed tasks cover reset values, each output mode, DC leaving N alone,
// zero and nonzero gaps, register extremes, discharge slots and output
// back-pressure; a random part follows. Both stream sides idle at random.
// Registers are only written once the block has drained.
// ----------------------------------------------------------------------------
module tb_stimulation_pulse_sequencer;
  import spsq_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned MAX_REPORTS = 100;   // mismatch lines printed
  // Address past the register file; writes there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  // Shadow of the register file as the block sees it
  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [15:0]        full_scale;
    logic [15:0]        trig_us;
    logic [15:0]        slot_gap_ms;
    logic [15:0]        slot_count;
    logic [15:0]        sense_gap_ms;
    out_mode_e          mode;
  } seq_settings_t;

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    s_tvalid_i  = 1'b0;
  logic                    s_tready_o;
  logic [IN_TDATA_W-1:0]   s_tdata_i   = '0;
  logic                    m_tvalid_o;
  logic                    m_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i  = '0;

  stimulation_pulse_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state
  // --------------------------------------------------------------------------
  seq_settings_t     regs;
  phase_e            ph;
  longint unsigned   ph_left;    // ticks left in the current phase
  logic [SLOT_W-1:0] slot_cnt;
  logic              pol;        // alternating polarity, flips before a trigger
  logic [TOG_W-1:0]  tog_cnt;
  logic              p_lvl;
  logic              n_lvl;
  logic [DUTY_W-1:0] duty_lvl;

  result_t tick_results_q[$];    // expected output words, oldest first
  int unsigned fail_cnt;
  bit quiet;                     // no random idling on either side
  bit hold_kick;                 // toggled to request one long receiver hold

  function automatic longint unsigned gap_ticks(input logic [15:0] ms);
    longint unsigned t;
    t = longint'(ms) * TICKS_PER_MS;
    return (t == 0) ? 1 : t;
  endfunction

  function automatic void enter_slot_gap();
    ph      = PH_SGAP;
    ph_left = gap_ticks(regs.slot_gap_ms);
  endfunction

  function automatic void enter_sense_gap();
    ph      = PH_CGAP;
    ph_left = gap_ticks(regs.sense_gap_ms);
  endfunction

  function automatic void enter_trigger();
    if (regs.mode == MODE_ALT) begin
      pol = ~pol;
    end
    // zero width: no pin activity, straight on to the slot gap
    if (regs.trig_us == 0) begin
      enter_slot_gap();
      return;
    end
    case (regs.mode)
      MODE_ALT: begin
        p_lvl = pol;
        n_lvl = ~pol;
      end
      MODE_POS: begin
        p_lvl = 1'b1;
        n_lvl = 1'b0;
      end
      MODE_NEG: begin
        p_lvl = 1'b0;
        n_lvl = 1'b1;
      end
      default: begin
        p_lvl = 1'b1;  // DC: N keeps whatever it had
      end
    endcase
    ph      = PH_TRIG;
    ph_left = regs.trig_us;
  endfunction

  function automatic void flip_pins();
    p_lvl   = ~p_lvl;
    n_lvl   = ~n_lvl;
    ph_left = TOGGLE_PERIOD_TICKS;
  endfunction

  function automatic void enter_slot();
    int unsigned lim;
    if (regs.level != 0) begin
      lim      = (int'(regs.full_scale) * DUTY_LIMIT_PCT) / PCT_SCALE;
      duty_lvl = DUTY_W'((int'(regs.level) * lim) / PCT_SCALE);
      enter_trigger();
    end else begin
      // discharge slot: boost off, wait, then toggle both pins
      duty_lvl = '0;
      ph       = PH_DWAIT;
      ph_left  = DISCHARGE_WAIT_TICKS;
    end
  endfunction

  function automatic void start_cycle();
    slot_cnt = '0;
    if (regs.slot_count != 0) begin
      enter_slot();
    end else begin
      enter_sense_gap();
    end
  endfunction

  function automatic void finish_phase();
    case (ph)
      PH_DWAIT: begin
        ph      = PH_DTOG;
        tog_cnt = 1;
        flip_pins();
      end
      PH_DTOG: begin
        if (tog_cnt < DISCHARGE_TOGGLES) begin
          tog_cnt = tog_cnt + 1'b1;
          flip_pins();
        end else begin
          enter_trigger();
        end
      end
      PH_TRIG: begin
        p_lvl = 1'b0;
        if (regs.mode != MODE_DC) begin
          n_lvl = 1'b0;
        end
        enter_slot_gap();
      end
      PH_SGAP: begin
        slot_cnt = slot_cnt + 1'b1;
        if (slot_cnt < regs.slot_count) begin
          enter_slot();
        end else begin
          enter_sense_gap();
        end
      end
      default: begin
        start_cycle();
      end
    endcase
  endfunction

  // Advance the predictor by one tick and return the word it produces
  function automatic result_t step_sequencer(input logic run);
    result_t r;
    logic    last;
    last = 1'b0;
    if (!run) begin
      ph       = PH_IDLE;
      ph_left  = 0;
      slot_cnt = '0;
    end else begin
      if (ph == PH_IDLE) begin
        start_cycle();
      end
      last = (ph == PH_CGAP) && (ph_left == 1);
    end
    r.boost_duty = duty_lvl;
    r.net_p      = p_lvl;
    r.net_n      = n_lvl;
    r.slot_index = slot_cnt;
    r.cycle_end  = last;
    if (ph != PH_IDLE) begin
      if (ph_left > 0) begin
        ph_left--;
      end
      if (ph_left == 0) begin
        finish_phase();
      end
    end
    return r;
  endfunction

  function automatic seq_settings_t make_settings(
    input logic [LEVEL_W-1:0] level,
    input logic [15:0]        full_scale,
    input logic [15:0]        trig_us,
    input logic [15:0]        slot_gap_ms,
    input logic [15:0]        slot_count,
    input logic [15:0]        sense_gap_ms,
    input out_mode_e          mode
  );
    seq_settings_t s;
    s.level        = level;
    s.full_scale   = full_scale;
    s.trig_us      = trig_us;
    s.slot_gap_ms  = slot_gap_ms;
    s.slot_count   = slot_count;
    s.sense_gap_ms = sense_gap_ms;
    s.mode         = mode;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      // cap the log; every mismatch still counts
      if (fail_cnt < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      // word layout from bit 0: duty, P, N, slot index, cycle end
      got.boost_duty = m_tdata_o[15:0];
      got.net_p      = m_tdata_o[16];
      got.net_n      = m_tdata_o[17];
      got.slot_index = m_tdata_o[33:18];
      got.cycle_end  = m_tdata_o[34];
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, m_tdata_o);
        fail_cnt++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("boost_duty", want.boost_duty, got.boost_duty);
        check_field("net_p", want.net_p, got.net_p);
        check_field("net_n", want.net_n, got.net_n);
        check_field("slot_index", want.slot_index, got.slot_index);
        check_field("cycle_end", want.cycle_end, got.cycle_end);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here on request
  // --------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_seen;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else if (hold_kick != hold_seen) begin
      hold_seen  <= hold_kick;
      hold_left  <= HOLD_CYCLES;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= quiet || ($urandom_range(99, 0) >= 6);
    end
  end

  // Watchdog: too long without any handshake means the block hung
  int unsigned stall_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stimulation_pulse_sequencer regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One tick word; valid stays high afterwards unless the next word idles.
  task automatic send_tick(input logic run);
    if (!quiet && $urandom_range(99, 0) < 6) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= IN_TDATA_W'(run);
    do @(posedge clk_i); while (!s_tready_o);
    tick_results_q.push_back(step_sequencer(run));
  endtask

  task automatic send_run(input int unsigned n, input logic run);
    repeat (n) send_tick(run);
  endtask

  // Stop offering ticks and let every outstanding word come out
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after its last write.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      REG_SENSE_LEVEL:     regs.level        = data[LEVEL_W-1:0];
      REG_DUTY_FULL_SCALE: regs.full_scale   = data;
      REG_TRIGGER_WIDTH:   regs.trig_us      = data;
      REG_SLOT_GAP:        regs.slot_gap_ms  = data;
      REG_SLOTS_PER_SENSE: regs.slot_count   = data;
      REG_SENSE_GAP:       regs.sense_gap_ms = data;
      REG_OUTPUT_MODE:     regs.mode         = out_mode_e'(data[1:0]);
      default: ;
    endcase
  endtask

  task automatic load_settings(input seq_settings_t s);
    settle();
    cfg_write(REG_SENSE_LEVEL, 16'(s.level));
    cfg_write(REG_DUTY_FULL_SCALE, s.full_scale);
    cfg_write(REG_TRIGGER_WIDTH, s.trig_us);
    cfg_write(REG_SLOT_GAP, s.slot_gap_ms);
    cfg_write(REG_SLOTS_PER_SENSE, s.slot_count);
    cfg_write(REG_SENSE_GAP, s.sense_gap_ms);
    cfg_write(REG_OUTPUT_MODE, 16'(s.mode));
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values: level 0, so the first slot sits in the discharge wait
  task automatic test_reset_values();
    send_run(20, 1'b1);
    send_tick(1'b0);
  endtask

  // Each bridge mode with short slots, then a suppressed trigger
  task automatic test_output_modes();
    out_mode_e modes[4];
    modes = '{MODE_ALT, MODE_POS, MODE_NEG, MODE_DC};
    foreach (modes[i]) begin
      load_settings(make_settings(50, 1000, 2, 0, 3, 0, modes[i]));
      send_run(24, 1'b1);
    end
    load_settings(make_settings(75, 4000, 0, 0, 2, 0, MODE_ALT));
    send_run(12, 1'b1);
    send_tick(1'b0);
  endtask

  // Switch to DC mid-trigger: the trigger end rereads the mode and keeps N high
  task automatic test_dc_keeps_n();
    load_settings(make_settings(30, 200, 20, 0, 2, 0, MODE_NEG));
    send_run(6, 1'b1);
    settle();
    cfg_write(REG_OUTPUT_MODE, 16'(MODE_DC));
    cfg_valid_i <= 1'b0;
    send_run(60, 1'b1);
    send_tick(1'b0);
  endtask

  // No slots with a zero sense gap (cycle end every tick), then 1 ms gaps
  task automatic test_gap_lengths();
    load_settings(make_settings(10, 900, 3, 0, 0, 0, MODE_POS));
    send_run(8, 1'b1);
    load_settings(make_settings(20, 300, 2, 1, 1, 1, MODE_POS));
    send_run(2010, 1'b1);
    send_tick(1'b0);
  endtask

  // Largest register values, masked data bits, an unused address, tiny scales
  task automatic test_register_extremes();
    settle();
    cfg_write(REG_SENSE_LEVEL, 16'hFFFF);     // upper bits dropped: level 127
    cfg_write(REG_DUTY_FULL_SCALE, 16'hFFFF);
    cfg_write(REG_TRIGGER_WIDTH, 16'hFFFF);
    cfg_write(REG_SLOT_GAP, 16'hFFFF);
    cfg_write(REG_SLOTS_PER_SENSE, 16'hFFFF);
    cfg_write(REG_SENSE_GAP, 16'hFFFF);
    cfg_write(REG_OUTPUT_MODE, 16'hFFFE);     // decodes to negative
    cfg_write(REG_UNUSED, 16'h5A5A);
    cfg_valid_i <= 1'b0;
    send_run(40, 1'b1);                       // parked in a maximal trigger
    send_tick(1'b0);
    load_settings(make_settings(127, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_ALT));
    send_run(40, 1'b1);                       // parked in a maximal slot gap
    send_tick(1'b0);
    load_settings(make_settings(127, 16'hFFFF, 1, 0, 0, 16'hFFFF, MODE_POS));
    send_run(30, 1'b1);                       // parked in a maximal sense gap
    send_tick(1'b0);
    load_settings(make_settings(1, 0, 1, 0, 16'hFFFF, 0, MODE_NEG));
    send_run(40, 1'b1);                       // zero full scale, slot count climbs
    send_tick(1'b0);
    load_settings(make_settings(127, 1, 1, 0, 3, 0, MODE_DC));
    send_run(20, 1'b1);
    load_settings(make_settings(1, 16'hFFFF, 1, 0, 3, 0, MODE_ALT));
    send_run(20, 1'b1);
    send_tick(1'b0);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    load_settings(make_settings(100, 16'hFFFF, 3, 0, 4, 0, MODE_ALT));
    hold_kick <= ~hold_kick;
    send_run(150, 1'b1);
    send_tick(1'b0);
  endtask

  // Full discharge slot: wait, every pin toggle, trigger, into the next cycle
  task automatic test_discharge_slot();
    load_settings(make_settings(0, 500, 4, 0, 1, 0, MODE_ALT));
    send_run(4230, 1'b1);
    send_tick(1'b0);
  endtask

  // Random settings with short timing; run mostly high with rare restarts
  task automatic test_random_traffic();
    seq_settings_t s;
    for (int seg = 0; seg < 16; seg++) begin
      s.level        = LEVEL_W'($urandom_range(127, 1));
      s.full_scale   = 16'($urandom_range(65535, 0));
      s.trig_us      = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(40, 7))
                                                    : 16'($urandom_range(6, 0));
      s.slot_gap_ms  = '0;
      s.slot_count   = 16'($urandom_range(6, 0));
      s.sense_gap_ms = '0;
      s.mode         = out_mode_e'($urandom_range(3, 0));
      load_settings(s);
      quiet <= (seg == 7);  // one long stretch with no idling at all
      repeat (97) send_tick($urandom_range(99, 0) >= 2);
    end
    quiet <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    regs     = make_settings(0, 255, 50, 3, 6, 100, MODE_ALT);  // reset values
    ph       = PH_IDLE;
    ph_left  = 0;
    slot_cnt = '0;
    pol      = 1'b0;
    tog_cnt  = '0;
    p_lvl    = 1'b0;
    n_lvl    = 1'b0;
    duty_lvl = '0;
    fail_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_output_modes();
    test_dc_keeps_n();
    test_gap_lengths();
    test_register_extremes();
    test_output_backpressure();
    test_discharge_slot();
    test_random_traffic();

    settle();
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("stimulation_pulse_sequencer regression: pass");
    end else begin
      $display("stimulation_pulse_sequencer regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/spsq_pkg.sv
hw/rtl/spsq_cfg.sv
hw/rtl/spsq_core.sv
hw/rtl/stimulation_pulse_sequencer.sv
bench/tb_stimulation_pulse_sequencer.sv
